// ----- rtl/core/allm_pkg.sv -----
// shared types and constants for the array linked list manager
package allm_pkg;

    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int LEN_W     = 7;
    localparam int CAP_W     = 7;
    localparam int CAP_RESET = 64;

    typedef enum logic [3:0] {
        ACT_APPEND     = 4'd0,
        ACT_INS_BEFORE = 4'd1,
        ACT_INS_AFTER  = 4'd2,
        ACT_REMOVE     = 4'd3,
        ACT_FIRST      = 4'd4,
        ACT_NEXT       = 4'd5,
        ACT_LAST       = 4'd6,
        ACT_PREV       = 4'd7,
        ACT_READ       = 4'd8
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_NULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_NEXT_CHK,
        S_RD_VAL,
        S_INS_POP,
        S_INS_NBR,
        S_INS_NEW,
        S_INS_OLD,
        S_REM_UNLINK,
        S_REM_FREE,
        S_FINISH
    } seq_state_t;

    typedef struct packed {
        action_t            action;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   result_position;
        logic [VAL_W-1:0]   result_value;
        logic [LEN_W-1:0]   list_length;
        logic               is_empty;
        logic               is_full;
    } rsp_t;

endpackage

// ----- rtl/core/allm_link_store.sv -----
// link table memory with a fill mark standing in for its reset contents
module allm_link_store
#(
    parameter int DEPTH = 64,
    localparam int SLOT_W = $clog2(DEPTH),
    localparam int LINK_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [LINK_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [LINK_W-1:0] wr_data
);

    logic [LINK_W-1:0] link_mem [DEPTH];
    logic [LINK_W-1:0] mem_rd_reg;
    logic [LINK_W-1:0] fresh_rd_reg;
    logic              fresh_sel_reg;
    logic [LINK_W-1:0] fill_reg;
    logic [LINK_W-1:0] fill_next;

    // slots at or above the fill mark were never written and still link to slot + 1
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (LINK_W'(wr_addr) >= fill_reg))
        begin
            fill_next = LINK_W'(wr_addr) + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg    <= link_mem[rd_addr];
            fresh_sel_reg <= (LINK_W'(rd_addr) >= fill_reg);
            fresh_rd_reg  <= LINK_W'(rd_addr) + 1'b1;
        end
    end

    assign rd_data = fresh_sel_reg ? fresh_rd_reg : mem_rd_reg;

endmodule

// ----- rtl/core/array_linked_list_manager.sv -----
// a rejected beat goes from dispatch straight to the result; a first reads the head value on the way,
// and walks visit the list one element at a time, longest for an append to a list of DEPTH - 1 elements.
// throughput: one beat at a time; the link walk reads one table entry per cycle. the next beat
// is taken the cycle after the result is loaded, which waits while the output beat is stalled.
// reset: empty list, all slots on the free chain (tracked by a fill mark, no clearing pass),
// capacity = min(64, DEPTH); the value store is not initialized.
module array_linked_list_manager
    import allm_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int LINK_W  = $clog2(DEPTH + 1);
    localparam int CMP_W   = (LINK_W > POS_W) ? LINK_W : POS_W;
    localparam int CFG_CW  = (LINK_W > CAP_W) ? LINK_W : CAP_W;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(DEPTH);

    seq_state_t state_reg, state_next;
    action_t    act_reg, act_next;
    status_t    status_reg, status_next;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0] val_reg, val_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     free_reg, free_next;
    logic [LINK_W-1:0]     len_reg, len_next;
    logic [LINK_W-1:0]     cap_reg, cap_next;
    logic [LINK_W-1:0]     pv_reg, pv_next;
    logic [LINK_W-1:0]     tgt_reg, tgt_next;
    logic [LINK_W-1:0]     rp_reg, rp_next;
    logic [LINK_W-1:0]     new_free_reg, new_free_next;
    logic                  walk_first_reg, walk_first_next;
    logic                  from_mem_reg, from_mem_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic              link_rd_en;
    logic [SLOT_W-1:0] link_rd_addr;
    logic [LINK_W-1:0] link_rd_data;
    logic              link_wr_en;
    logic [SLOT_W-1:0] link_wr_addr;
    logic [LINK_W-1:0] link_wr_data;

    logic [ELEM_WIDTH-1:0] val_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] val_rd_data_reg;
    logic                  val_rd_en;
    logic [SLOT_W-1:0]     val_rd_addr;
    logic                  val_wr_en;

    logic [LINK_W-1:0] cur_now;
    logic [LINK_W-1:0] nbr;
    logic              cur_nil;
    logic              last_mode;
    logic              hit;
    logic              list_empty;
    logic              list_full;
    logic              val_null;
    logic              pv_nil;
    logic              room_out;

    allm_link_store #(
        .DEPTH (DEPTH)
    ) u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (val_wr_en)
        begin
            val_mem[rp_reg[SLOT_W-1:0]] <= val_reg;
        end
        if (val_rd_en)
        begin
            val_rd_data_reg <= val_mem[val_rd_addr];
        end
    end

    // walk cursor: head on the first step, then the link just read
    assign cur_now    = walk_first_reg ? head_reg : link_rd_data;
    assign cur_nil    = (cur_now >= NIL);
    assign last_mode  = (act_reg == ACT_APPEND) || (act_reg == ACT_LAST);
    assign hit        = !cur_nil && !last_mode && (CMP_W'(cur_now) == CMP_W'(pos_reg));
    assign list_empty = (len_reg == '0) || (head_reg >= NIL);
    assign list_full  = (len_reg >= cap_reg) || (free_reg >= NIL);
    assign val_null   = (val_reg == '0);
    assign pv_nil     = (pv_reg >= NIL);
    assign nbr        = (act_reg == ACT_INS_AFTER) ? tgt_reg : pv_reg;
    assign room_out   = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (act_reg) inside
                    ACT_APPEND:
                    begin
                        if (list_full || val_null)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (list_empty)
                        begin
                            state_next = S_INS_POP;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    ACT_INS_BEFORE, ACT_INS_AFTER:
                    begin
                        state_next = (list_full || val_null) ? S_FINISH : S_WALK;
                    end
                    ACT_REMOVE, ACT_NEXT, ACT_PREV, ACT_READ, ACT_LAST:
                    begin
                        state_next = list_empty ? S_FINISH : S_WALK;
                    end
                    ACT_FIRST:
                    begin
                        state_next = list_empty ? S_FINISH : S_RD_VAL;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WALK:
            begin
                if (cur_nil)
                begin
                    if (last_mode)
                    begin
                        state_next = (act_reg == ACT_APPEND) ? S_INS_POP : S_RD_VAL;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (hit)
                begin
                    unique case (act_reg) inside
                        ACT_NEXT:                      state_next = S_NEXT_CHK;
                        ACT_PREV:                      state_next = pv_nil ? S_FINISH : S_RD_VAL;
                        ACT_READ:                      state_next = S_RD_VAL;
                        ACT_REMOVE:                    state_next = S_REM_UNLINK;
                        ACT_INS_BEFORE, ACT_INS_AFTER: state_next = S_INS_POP;
                        default:                       state_next = S_FINISH;
                    endcase
                end
            end
            S_NEXT_CHK:
            begin
                state_next = (link_rd_data >= NIL) ? S_FINISH : S_RD_VAL;
            end
            S_RD_VAL:     state_next = S_FINISH;
            S_INS_POP:    state_next = S_INS_NBR;
            S_INS_NBR:    state_next = S_INS_NEW;
            S_INS_NEW:    state_next = S_INS_OLD;
            S_INS_OLD:    state_next = S_FINISH;
            S_REM_UNLINK: state_next = S_REM_FREE;
            S_REM_FREE:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (room_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath, table accesses and result beat
    always_comb
    begin
        act_next        = act_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        len_next        = len_reg;
        cap_next        = cap_reg;
        pv_next         = pv_reg;
        tgt_next        = tgt_reg;
        rp_next         = rp_reg;
        new_free_next   = new_free_reg;
        walk_first_next = walk_first_reg;
        status_next     = status_reg;
        from_mem_next   = from_mem_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        link_rd_en   = 1'b0;
        link_rd_addr = cur_now[SLOT_W-1:0];
        link_wr_en   = 1'b0;
        link_wr_addr = rp_reg[SLOT_W-1:0];
        link_wr_data = rp_reg;
        val_rd_en    = 1'b0;
        val_rd_addr  = rp_reg[SLOT_W-1:0];
        val_wr_en    = 1'b0;

        // capacity is clamped to 1 .. DEPTH
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                cap_next = LINK_W'(1);
            end
            else if (CFG_CW'(cfg_wr_data) > CFG_CW'(DEPTH))
            begin
                cap_next = NIL;
            end
            else
            begin
                cap_next = LINK_W'(cfg_wr_data);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    pos_next = req.position;
                    val_next = ELEM_WIDTH'(req.value);
                end
            end
            S_DISPATCH:
            begin
                walk_first_next = 1'b1;
                pv_next         = NIL;
                from_mem_next   = 1'b0;
                status_next     = STAT_OK;
                unique case (act_reg) inside
                    ACT_APPEND, ACT_INS_BEFORE, ACT_INS_AFTER:
                    begin
                        if (list_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (val_null)
                        begin
                            status_next = STAT_NULL;
                        end
                    end
                    ACT_REMOVE, ACT_NEXT, ACT_PREV, ACT_READ, ACT_LAST:
                    begin
                        if (list_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    ACT_FIRST:
                    begin
                        if (list_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        rp_next = head_reg;
                    end
                    default:
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                endcase
            end
            S_WALK:
            begin
                if (cur_nil)
                begin
                    if (last_mode)
                    begin
                        rp_next = pv_reg;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                else if (hit)
                begin
                    tgt_next = cur_now;
                    unique case (act_reg) inside
                        ACT_NEXT:
                        begin
                            link_rd_en = 1'b1;
                        end
                        ACT_PREV:
                        begin
                            if (pv_nil)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            rp_next = pv_reg;
                        end
                        ACT_READ:
                        begin
                            rp_next = cur_now;
                        end
                        ACT_REMOVE:
                        begin
                            link_rd_en  = 1'b1;
                            val_rd_en   = 1'b1;
                            val_rd_addr = cur_now[SLOT_W-1:0];
                            rp_next     = cur_now;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    link_rd_en      = 1'b1;
                    pv_next         = cur_now;
                    walk_first_next = 1'b0;
                end
            end
            S_NEXT_CHK:
            begin
                if (link_rd_data >= NIL)
                begin
                    status_next = STAT_NOT_FOUND;
                end
                rp_next = link_rd_data;
            end
            S_RD_VAL:
            begin
                val_rd_en     = 1'b1;
                from_mem_next = 1'b1;
            end
            S_INS_POP:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = free_reg[SLOT_W-1:0];
                rp_next      = free_reg;
            end
            S_INS_NBR:
            begin
                new_free_next = link_rd_data;
                link_rd_en    = (nbr < NIL);
                link_rd_addr  = nbr[SLOT_W-1:0];
            end
            S_INS_NEW:
            begin
                link_wr_en = 1'b1;
                val_wr_en  = 1'b1;
                if (act_reg == ACT_APPEND)
                begin
                    link_wr_data = NIL;
                end
                else if ((act_reg == ACT_INS_BEFORE) && pv_nil)
                begin
                    link_wr_data = head_reg;
                end
                else
                begin
                    link_wr_data = link_rd_data;
                end
            end
            S_INS_OLD:
            begin
                // new slot becomes the head when it has no predecessor
                if (pv_nil && (act_reg != ACT_INS_AFTER))
                begin
                    head_next = rp_reg;
                end
                else
                begin
                    link_wr_en   = 1'b1;
                    link_wr_addr = nbr[SLOT_W-1:0];
                    link_wr_data = rp_reg;
                end
                free_next = new_free_reg;
                len_next  = len_reg + 1'b1;
            end
            S_REM_UNLINK:
            begin
                if (pv_nil)
                begin
                    head_next = link_rd_data;
                end
                else
                begin
                    link_wr_en   = 1'b1;
                    link_wr_addr = pv_reg[SLOT_W-1:0];
                    link_wr_data = link_rd_data;
                end
            end
            S_REM_FREE:
            begin
                link_wr_en    = 1'b1;
                link_wr_data  = free_reg;
                free_next     = rp_reg;
                len_next      = len_reg - 1'b1;
                from_mem_next = 1'b1;
            end
            S_FINISH:
            begin
                if (room_out)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = status_reg;
                    rsp_next.result_position = '0;
                    rsp_next.result_value   = '0;
                    if (status_reg == STAT_OK)
                    begin
                        rsp_next.result_position = POS_W'(rp_reg);
                        rsp_next.result_value    = from_mem_reg ? VAL_W'(val_rd_data_reg)
                                                                : VAL_W'(val_reg);
                    end
                    rsp_next.list_length = LEN_W'(len_reg);
                    rsp_next.is_empty    = (len_reg == '0);
                    rsp_next.is_full     = (len_reg >= cap_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            free_reg      <= '0;
            len_reg       <= '0;
            cap_reg       <= LINK_W'(CAP_RST);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            len_reg       <= len_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        pv_reg         <= pv_next;
        tgt_reg        <= tgt_next;
        rp_reg         <= rp_next;
        new_free_reg   <= new_free_next;
        walk_first_reg <= walk_first_next;
        status_reg     <= status_next;
        from_mem_reg   <= from_mem_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
